// ===== rtl/timed_lock_table_core_assert.svh =====
// Assertion macros for the lock table. Each expects clk and rst in scope.
`ifndef TIMED_LOCK_TABLE_CORE_ASSERT_SVH
`define TIMED_LOCK_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tlt_pkg.sv =====
package tlt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam logic [31:0] TIMEOUT_RESET = 32'd2000;

  typedef enum logic [1:0] {
    OP_LOCK   = 2'd0,
    OP_UNLOCK = 2'd1,
    OP_QUERY  = 2'd2,
    OP_TICK   = 2'd3
  } tlt_op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } tlt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } tlt_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] chunk_id;
  } tlt_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       is_locked;
    logic [4:0] entries_used;
  } tlt_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } tlt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic rsp_free;
  } tlt_sts_t;

endpackage

// ===== rtl/tlt_ctrl.sv =====
module tlt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  tlt_pkg::tlt_op_t req_op,
  input  tlt_pkg::tlt_sts_t sts,
  output tlt_pkg::tlt_cmd_t cmd,
  output logic             req_stall
);

  tlt_pkg::tlt_state_t state;
  tlt_pkg::tlt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tlt_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req_op == tlt_pkg::OP_UNLOCK || req_op == tlt_pkg::OP_QUERY) begin
            state_next = tlt_pkg::S_SCAN;
          end else begin
            state_next = tlt_pkg::S_DONE;
          end
        end
      end
      tlt_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_next = tlt_pkg::S_DONE;
        end
      end
      tlt_pkg::S_DONE: begin
        if (sts.rsp_free) begin
          state_next = tlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tlt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      tlt_pkg::S_IDLE: begin
        req_stall = 1'b0;
        cmd.start = req_valid;
      end
      tlt_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      tlt_pkg::S_DONE: begin
        cmd.finish = sts.rsp_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/tlt_dp.sv =====
module tlt_dp #(
  parameter int TABLE_ENTRIES = tlt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tlt_pkg::tlt_req_t req,
  input  tlt_pkg::tlt_cmd_t cmd,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              rsp_stall,
  output tlt_pkg::tlt_sts_t sts,
  output logic              rsp_valid,
  output tlt_pkg::tlt_rsp_t rsp
);

  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  logic [31:0] ids    [TABLE_ENTRIES];
  logic [31:0] stamps [TABLE_ENTRIES];
  logic [31:0] q_id;
  logic [31:0] q_stamp;

  tlt_pkg::tlt_op_t op;
  logic [31:0]      id;
  logic [31:0]      now;
  logic [31:0]      timeout;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] wr_idx;
  logic             pend;
  logic             hit;

  logic             rd_lt;
  logic             expired;
  logic             match;
  logic             keep;
  logic             full;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [31:0]      mem_wid;
  logic [31:0]      mem_wst;
  tlt_pkg::tlt_rsp_t rsp_next;

  assign rd_lt   = rd_idx < count;
  assign expired = (now - q_stamp) > timeout;
  assign match   = q_id == id;
  assign full    = count == FULL_COUNT;

  // Unlock drops only the first match; query drops every expired entry.
  always_comb begin
    keep = 1'b1;
    case (op)
      tlt_pkg::OP_UNLOCK: keep = !(match && !hit);
      tlt_pkg::OP_QUERY:  keep = !expired;
      default:            keep = 1'b1;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = wr_idx[ADDR_W-1:0];
    mem_wid = q_id;
    mem_wst = q_stamp;
    if (cmd.scan && pend && keep) begin
      mem_we = 1'b1;
    end else if (cmd.finish && op == tlt_pkg::OP_LOCK && !full) begin
      mem_we  = 1'b1;
      mem_wa  = count[ADDR_W-1:0];
      mem_wid = id;
      mem_wst = now;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ids[mem_wa]    <= mem_wid;
      stamps[mem_wa] <= mem_wst;
    end
    q_id    <= ids[rd_idx[ADDR_W-1:0]];
    q_stamp <= stamps[rd_idx[ADDR_W-1:0]];
  end

  always_comb begin
    count_next = count;
    rsp_next   = '0;
    case (op)
      tlt_pkg::OP_LOCK: begin
        if (full) begin
          rsp_next.status = tlt_pkg::ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      tlt_pkg::OP_UNLOCK: begin
        count_next = wr_idx;
        if (!hit) begin
          rsp_next.status = tlt_pkg::ST_MISS;
        end
      end
      tlt_pkg::OP_QUERY: begin
        count_next         = wr_idx;
        rsp_next.is_locked = hit;
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.entries_used = 5'(count_next);
  end

  // Request and scan registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op     <= tlt_pkg::tlt_op_t'(req.opcode);
      id     <= req.chunk_id;
      rd_idx <= '0;
      wr_idx <= '0;
      hit    <= 1'b0;
    end else if (cmd.scan) begin
      if (rd_lt) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (pend) begin
        if (keep) begin
          wr_idx <= wr_idx + CNT_W'(1);
        end
        if (op == tlt_pkg::OP_UNLOCK) begin
          hit <= hit | match;
        end else begin
          hit <= hit | (keep && match);
        end
      end
    end
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      count     <= '0;
      now       <= '0;
      timeout   <= tlt_pkg::TIMEOUT_RESET;
      rsp_valid <= 1'b0;
    end else begin
      pend <= cmd.scan && rd_lt;
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (cmd.finish) begin
        count <= count_next;
        if (op == tlt_pkg::OP_TICK) begin
          now <= now + 32'd1;
        end
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.scan_done = !rd_lt && !pend;
  assign sts.rsp_free  = !rsp_valid || !rsp_stall;

endmodule

// ===== rtl/timed_lock_table_core.sv =====
// Ordered lock table with expiry, one request at a time. Lock and tick requests go from
// the idle state straight to the done state; unlock and query stream the table once
// through an entry memory with one read and one write port, compacting it in place.
// Query first drops every entry older than timeout_ticks (age wraps modulo 2^32), then
// answers from the survivors; unlock removes the oldest matching entry. A finished
// result waits in the output register, but no new request is taken until the current
// one is done. Write timeout_ticks via cfg_we/cfg_wdata only while the block is idle.
`include "timed_lock_table_core_assert.svh"

module timed_lock_table_core #(
  parameter int TABLE_ENTRIES = tlt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tlt_pkg::tlt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tlt_pkg::tlt_rsp_t rsp,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  tlt_pkg::tlt_cmd_t cmd;
  tlt_pkg::tlt_sts_t sts;

  tlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (tlt_pkg::tlt_op_t'(req.opcode)),
    .sts       (sts),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  tlt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  `TLT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "taken while busy")
  `TLT_ASSERT_NEXT(a_finish_gives_rsp, cmd.finish, rsp_valid, "finished request left no result")
  `TLT_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid), $past(cmd.finish), "result without finish")

endmodule
